// ===== hw/rtl/xbe_pkg.sv =====
// Shared types, constants and the base64 alphabet function for the XOR base64 encoder.
`timescale 1ns / 1ps
`default_nettype none

package xbe_pkg;

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W = 64;
   localparam int KEY_POS_W = 3;
   localparam int KEY_LEN_W = 4;
   localparam int CODE_W = 6;
   localparam int MAX_CHARS = 4;

   localparam logic [7:0] PAD_CHAR = 8'h3D;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KEY_BYTES  = 4'd0,
      CSR_KEY_LENGTH = 4'd1
   } csr_index_type;

   // One accepted byte as the back end sees it: up to two alphabet codes,
   // then padding up to the character count.
   typedef struct packed {
      logic [MAX_CHARS-1:0][CODE_W-1:0] codes;
      logic [1:0]                       ndata;
      logic [2:0]                       nchar;
      logic                             last;
   } xbe_entry_type;

   function automatic logic [7:0] b64_char(input logic [CODE_W-1:0] code);
      logic [7:0] c;
      c = {2'b00, code};
      if (code < 6'd26) begin
         return 8'h41 + c;
      end else if (code < 6'd52) begin
         return 8'h61 + c - 8'd26;
      end else if (code < 6'd62) begin
         return 8'h30 + c - 8'd52;
      end else if (code == 6'd62) begin
         return 8'h2B;
      end else begin
         return 8'h2F;
      end
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/xor_base64_encoder_core.sv =====
// Top level of the repeating-key XOR base64 encoder.
`timescale 1ns / 1ps
`default_nettype none

// Takes one message byte per item, XORs it with the repeating key and emits the
// base64 characters one item per cycle unless the receiver stalls the output,
// with '=' padding and a flag on the last character of each message. A byte is
// accepted in the cycle it arrives while the queue of planned bytes has room;
// each byte yields one to four characters, and the character output, one per
// cycle, sets the sustained rate: about four characters per three bytes. With
// the queue and the output register empty, a byte's first character goes into
// a queue slot and then into the output register before it is offered.
// Configuration writes are always accepted and take effect from the next byte.
module xor_base64_encoder_core #(
   parameter int KEY_BYTES = 8,
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [xbe_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [xbe_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [7:0]                       req_data_byte,
   input  wire logic                             req_end_of_message,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [7:0]                            rsp_base64_char,
   output logic                                  rsp_final_char
);

   xbe_pkg::xbe_entry_type push_entry;
   xbe_pkg::xbe_entry_type head_entry;
   logic push_valid;
   logic push_ready;
   logic head_valid;
   logic pop;

   assign csr_ready = 1'b1;
   assign req_ready = push_ready;

   xbe_front #(
      .KEY_BYTES(KEY_BYTES)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_data_byte(req_data_byte),
      .req_end_of_message(req_end_of_message),
      .push_ready(push_ready),
      .push_entry(push_entry),
      .push_valid(push_valid)
   );

   xbe_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push_valid(push_valid),
      .push_entry(push_entry),
      .push_ready(push_ready),
      .pop(pop),
      .head_valid(head_valid),
      .head_entry(head_entry)
   );

   xbe_back u_back (
      .clock(clock),
      .reset(reset),
      .head_valid(head_valid),
      .head_entry(head_entry),
      .pop(pop),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_base64_char(rsp_base64_char),
      .rsp_final_char(rsp_final_char)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/xbe_front.sv =====
// Front end: key registers, key XOR, bit packing and per-byte character planning.
`timescale 1ns / 1ps
`default_nettype none

module xbe_front #(
   parameter int KEY_BYTES = 8
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_valid,
   input  wire logic [xbe_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [xbe_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  wire logic                               req_valid,
   input  wire logic [7:0]                         req_data_byte,
   input  wire logic                               req_end_of_message,
   input  wire logic                               push_ready,
   output xbe_pkg::xbe_entry_type                  push_entry,
   output logic                                    push_valid
);

   localparam int KEY_W = KEY_BYTES * 8;
   localparam logic [xbe_pkg::KEY_LEN_W-1:0] KEY_LEN_MAX = xbe_pkg::KEY_LEN_W'(KEY_BYTES);

   logic [KEY_W-1:0]                    key_ff;
   logic [xbe_pkg::KEY_LEN_W-1:0]       key_length_ff;
   logic [xbe_pkg::KEY_POS_W-1:0]       key_pos_ff, key_pos_in;
   logic [3:0]                          lbits_ff, lbits_in;
   logic [2:0]                          lcount_ff, lcount_in;
   logic [1:0]                          phase_ff, phase_in;

   logic [xbe_pkg::KEY_LEN_W-1:0]       eff_len;
   logic [xbe_pkg::KEY_POS_W-1:0]       pos_sel;
   logic [xbe_pkg::KEY_LEN_W-1:0]       pos_inc;
   logic [7:0]                          key_byte;
   logic [7:0]                          xb;
   logic [3:0]                          nbits_left;
   logic [2:0]                          ncount_left;
   logic [1:0]                          ndata;
   logic [1:0]                          ph;
   logic [1:0]                          pad;
   logic [2:0]                          total;
   xbe_pkg::xbe_entry_type              entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
         key_length_ff <= xbe_pkg::KEY_LEN_W'(1);
      end else if (csr_valid) begin
         if (csr_index == xbe_pkg::CSR_KEY_BYTES) begin
            key_ff <= csr_wdata[KEY_W-1:0];
         end else if (csr_index == xbe_pkg::CSR_KEY_LENGTH) begin
            key_length_ff <= csr_wdata[xbe_pkg::KEY_LEN_W-1:0];
         end
      end
   end

   always_comb begin
      if (key_length_ff == '0) begin
         eff_len = xbe_pkg::KEY_LEN_W'(1);
      end else if (key_length_ff > KEY_LEN_MAX) begin
         eff_len = KEY_LEN_MAX;
      end else begin
         eff_len = key_length_ff;
      end
      pos_sel = ({1'b0, key_pos_ff} >= eff_len) ? '0 : key_pos_ff;
      key_byte = key_ff[pos_sel*8 +: 8];
      xb = req_data_byte ^ key_byte;
      pos_inc = {1'b0, pos_sel} + xbe_pkg::KEY_LEN_W'(1);

      entry = '0;
      entry.last = req_end_of_message;
      unique case (lcount_ff)
         3'd2: begin
            entry.codes[0] = {lbits_ff[1:0], xb[7:4]};
            ndata = 2'd1;
            nbits_left = xb[3:0];
            ncount_left = 3'd4;
         end
         3'd4: begin
            entry.codes[0] = {lbits_ff[3:0], xb[7:6]};
            entry.codes[1] = xb[5:0];
            ndata = 2'd2;
            nbits_left = 4'd0;
            ncount_left = 3'd0;
         end
         default: begin
            entry.codes[0] = xb[7:2];
            ndata = 2'd1;
            nbits_left = {2'b00, xb[1:0]};
            ncount_left = 3'd2;
         end
      endcase

      if (req_end_of_message && ncount_left == 3'd2) begin
         entry.codes[ndata] = {nbits_left[1:0], 4'b0000};
         ndata = ndata + 2'd1;
      end else if (req_end_of_message && ncount_left == 3'd4) begin
         entry.codes[ndata] = {nbits_left, 2'b00};
         ndata = ndata + 2'd1;
      end

      ph = phase_ff + ndata;
      pad = req_end_of_message ? 2'(2'd0 - ph) : 2'd0;
      total = {1'b0, ndata} + {1'b0, pad};
      if (total > 3'd4) begin
         total = 3'd4;
      end
      entry.ndata = ndata;
      entry.nchar = total;

      if (req_end_of_message) begin
         key_pos_in = '0;
         lbits_in = '0;
         lcount_in = '0;
         phase_in = '0;
      end else begin
         key_pos_in = (pos_inc >= eff_len) ? '0 : pos_inc[xbe_pkg::KEY_POS_W-1:0];
         lbits_in = nbits_left;
         lcount_in = ncount_left;
         phase_in = ph;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_pos_ff <= '0;
         lbits_ff <= '0;
         lcount_ff <= '0;
         phase_ff <= '0;
      end else if (req_valid && push_ready) begin
         key_pos_ff <= key_pos_in;
         lbits_ff <= lbits_in;
         lcount_ff <= lcount_in;
         phase_ff <= phase_in;
      end
   end

   assign push_entry = entry;
   assign push_valid = req_valid && push_ready;

endmodule

`default_nettype wire

// ===== hw/rtl/xbe_queue.sv =====
// Small register queue of planned bytes between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module xbe_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push_valid,
   input  xbe_pkg::xbe_entry_type      push_entry,
   output logic                        push_ready,
   input  wire logic                   pop,
   output logic                        head_valid,
   output xbe_pkg::xbe_entry_type      head_entry
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   xbe_pkg::xbe_entry_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   always_comb begin
      do_push = push_valid && (count_ff != FULL_CNT);
      do_pop = pop && (count_ff != '0);
      wr_ptr_in = do_push ? ((wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1)) : wr_ptr_ff;
      rd_ptr_in = do_pop ? ((rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1)) : rd_ptr_ff;
      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign push_ready = (count_ff != FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// ===== hw/rtl/xbe_back.sv =====
// Back end: emits the characters of the head entry one per cycle, unless stalled, into the output register.
`timescale 1ns / 1ps
`default_nettype none

module xbe_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   head_valid,
   input  xbe_pkg::xbe_entry_type      head_entry,
   output logic                        pop,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [7:0]                  rsp_base64_char,
   output logic                        rsp_final_char
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] char_ff, char_in;
   logic       final_ff, final_in;
   logic       load;
   logic       at_end;

   always_comb begin
      load = head_valid && (!valid_ff || rsp_ready);
      at_end = (idx_ff == 2'(head_entry.nchar - 3'd1));
      char_in = (idx_ff < head_entry.ndata) ? xbe_pkg::b64_char(head_entry.codes[idx_ff])
                                            : xbe_pkg::PAD_CHAR;
      final_in = head_entry.last && at_end;
      pop = load && at_end;
      if (load) begin
         idx_in = at_end ? 2'd0 : idx_ff + 2'd1;
         valid_in = 1'b1;
      end else begin
         idx_in = idx_ff;
         valid_in = valid_ff && !rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         char_ff <= char_in;
         final_ff <= final_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_base64_char = char_ff;
   assign rsp_final_char = final_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/xbe_checker.sv =====
// Port-level checker for the XOR base64 encoder and its bind statement.
`timescale 1ns / 1ps
`default_nettype none

module xbe_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_valid,
   input wire logic                             req_ready,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_ready,
   input wire logic [7:0]                       rsp_base64_char,
   input wire logic                             rsp_final_char
);

   // A stalled item keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_base64_char)
                                  && $stable(rsp_final_char))
      else $error("Stalled result item changed.");

   // Nothing is offered right after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Result valid right after reset.");

   // An accepted byte must be followed by a valid result item once it has passed the queue and the output register.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> ##1 rsp_valid)
      else $error("No result item two cycles after an accepted byte.");

   // Padding runs without gaps until the last character of the message.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_base64_char == xbe_pkg::PAD_CHAR && !rsp_final_char
      |=> rsp_valid && rsp_base64_char == xbe_pkg::PAD_CHAR)
      else $error("Padding interrupted before the final character.");

endmodule

bind xor_base64_encoder_core xbe_checker u_xbe_checker (.*);

`default_nettype wire
